[hdl/console_line_editor_top_defines.svh]
// Assertion helpers for the console line editor
`ifndef CONSOLE_LINE_EDITOR_TOP_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_TOP_DEFINES_SVH

// same-cycle implication
`define CLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cle_pkg.sv]
`timescale 1ns / 1ps
package cle_pkg;

    // result kinds
    localparam logic [2:0] KIND_ECHO   = 3'd0;
    localparam logic [2:0] KIND_ERASE  = 3'd1;
    localparam logic [2:0] KIND_COMMIT = 3'd2;
    localparam logic [2:0] KIND_RECALL = 3'd3;
    localparam logic [2:0] KIND_FAIL   = 3'd4;

    // console bytes
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_UP       = 8'h41;
    localparam logic [7:0] CH_DOWN     = 8'h42;
    localparam logic [7:0] CH_DEL      = 8'h7f;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hc0;

    localparam logic [11:0] DEPTH_MAX  = 12'hfff;

    // escape phases
    localparam logic [1:0] ESC_NONE    = 2'd0;
    localparam logic [1:0] ESC_SEEN    = 2'd1;
    localparam logic [1:0] ESC_CSI     = 2'd2;

    // one result word
    typedef struct packed {
        logic        valid;
        logic [2:0]  kind;
        logic [7:0]  echo_char;
        logic [11:0] range_start;
        logic [12:0] range_length;
        logic        last;
    } cle_res_t;

    // completion word "exit"
    function automatic logic [7:0] exit_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0: c = 8'h65;
            2'd1: c = 8'h78;
            2'd2: c = 8'h69;
            default: c = 8'h74;
        endcase
        return c;
    endfunction

endpackage

[hdl/console_line_editor_top.sv]
`timescale 1ns / 1ps
// Console line editor.
// Input channel s_*: one console byte per word (s_data_byte), valid/ready.
// Result channel m_*: kind, echo_char, range_start, range_length, last;
// one byte gives zero to four result words, m_last marks the final one.
// A byte that gives no result (control bytes, ESC, ESC [) is simply absorbed.
// One byte is worked on at a time; s_ready is high only while idle.
// An ordinary byte goes through the decode, plain, echo and finish states
// before the block is idle again, a line end also through the commit state;
// its echo word passes the held-result register and the output register on
// its way to m_valid. Erase, line clear, history scan and the recall copy
// step through the store a byte at a time, paced by the single registered
// read port of the line store.
// A finished word sits in the output register while the next one is built;
// if m_ready stays low the sequencer waits before overwriting it, so nothing
// is lost. aresetn (synchronous, active low) clears the positions, history
// depth and escape phase; the line store itself is not cleared and needs no
// clearing pass.
module console_line_editor_top import cle_pkg::*; #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_echo_char,
    output logic [11:0] m_range_start,
    output logic [12:0] m_range_length,
    output logic        m_last
);

`include "console_line_editor_top_defines.svh"

    localparam int AW = $clog2(BUFFER_BYTES);

    cle_res_t      push;
    cle_res_t      out_reg;
    logic          out_free;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    cle_ctrl #(.BUFFER_BYTES(BUFFER_BYTES)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_data_byte (s_data_byte),
        .s_ready     (s_ready),
        .out_free    (out_free),
        .push        (push),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    cle_ram #(.BUFFER_BYTES(BUFFER_BYTES)) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register
    assign out_free = !out_reg.valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (push.valid) begin
            out_reg <= push;
        end else if (m_ready) begin
            out_reg.valid <= 1'b0;
        end
    end

    assign m_valid        = out_reg.valid;
    assign m_kind         = out_reg.kind;
    assign m_echo_char    = out_reg.echo_char;
    assign m_range_start  = out_reg.range_start;
    assign m_range_length = out_reg.range_length;
    assign m_last         = out_reg.last;

    // checks
    `CLE_ASSERT_NOW(a_push_room, push.valid, out_free, "result pushed into a full output register")
    `CLE_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "input taken while busy")
    `CLE_ASSERT_NOW(a_kind_range, m_valid, m_kind <= KIND_FAIL, "result kind out of range")

endmodule

[hdl/cle_ram.sv]
`timescale 1ns / 1ps
module cle_ram #(
    parameter int BUFFER_BYTES = 4096,
    localparam int AW = $clog2(BUFFER_BYTES)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/cle_ctrl.sv]
`timescale 1ns / 1ps
module cle_ctrl import cle_pkg::*; #(
    parameter int BUFFER_BYTES = 4096,
    localparam int AW = $clog2(BUFFER_BYTES),
    localparam int PW = $clog2(BUFFER_BYTES + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic [7:0]    s_data_byte,
    output logic          s_ready,
    input  logic          out_free,
    output cle_res_t      push,
    output logic          mem_we,
    output logic [AW-1:0] mem_waddr,
    output logic [7:0]    mem_wdata,
    output logic [AW-1:0] mem_raddr,
    input  logic [7:0]    mem_rdata
);

    localparam logic [PW-1:0] BUF_P = PW'(BUFFER_BYTES);
    localparam logic [PW:0]   BUF_X = (PW + 1)'(BUFFER_BYTES);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_PLAIN, ST_ORD_ECHO, ST_ORD_COMMIT,
        ST_ER_RD, ST_ER_CHK, ST_ER_EMIT, ST_AR_RD, ST_AR_CHK, ST_AR_POST,
        ST_SR_RD, ST_SR_CHK, ST_CP_SETUP, ST_CP_RD, ST_CP_WR, ST_CP_DONE,
        ST_CM_START, ST_CM_RD, ST_CM_CHK, ST_CM_PUT, ST_CM_FAIL, ST_FINISH
    } state_t;

    state_t         state_reg;
    logic [7:0]     byte_reg;
    logic [7:0]     k_reg;
    logic [1:0]     phase_reg;
    logic           plain_after_reg;
    logic           arrow_reg;
    logic [PW-1:0]  wp_reg;
    logic [PW-1:0]  ps_reg;
    logic [11:0]    hd_reg;
    logic [PW-1:0]  n_reg;
    logic [PW-1:0]  i_reg;
    logic [11:0]    t_reg;
    logic [PW-1:0]  end_reg;
    logic [PW-1:0]  start_reg;
    logic [PW-1:0]  len_reg;
    logic [PW-1:0]  dest_reg;
    logic [PW-1:0]  cnt_reg;
    logic           pend_valid_reg;
    cle_res_t       pend_reg;

    logic           emit_req;
    logic           emit_go;
    logic           emit_ok;
    cle_res_t       emit_res;
    logic           put_wrap;
    logic [AW-1:0]  put_addr;
    logic [PW-1:0]  put_wp;
    logic [PW-1:0]  rd_pos;
    logic [PW-1:0]  cp_pos;
    logic [PW-1:0]  sr_start;
    logic           sr_brk;
    logic           next_plain;

    assign s_ready = (state_reg == ST_IDLE);

    // storing one byte, with wrap when the store is full
    assign put_wrap = (wp_reg >= BUF_P);
    assign put_addr = put_wrap ? '0 : wp_reg[AW-1:0];
    assign put_wp   = put_wrap ? PW'(1) : wp_reg + PW'(1);

    assign next_plain = plain_after_reg;

    // history scan helpers
    assign sr_brk   = (i_reg == PW'(1)) || (mem_rdata == CH_LF);
    assign sr_start = (mem_rdata == CH_LF) ? i_reg : i_reg - PW'(1);
    assign cp_pos   = dest_reg + cnt_reg;

    // result request per state
    always_comb begin
        emit_req = 1'b0;
        emit_res = '0;
        emit_res.valid = 1'b1;
        case (state_reg)
            ST_ORD_ECHO: begin
                emit_req           = 1'b1;
                emit_res.kind      = KIND_ECHO;
                emit_res.echo_char = k_reg;
            end
            ST_ORD_COMMIT: begin
                emit_req              = 1'b1;
                emit_res.kind         = KIND_COMMIT;
                emit_res.range_start  = 12'(ps_reg);
                emit_res.range_length = 13'(wp_reg - ps_reg);
            end
            ST_ER_EMIT: begin
                emit_req              = (n_reg != '0);
                emit_res.kind         = KIND_ERASE;
                emit_res.range_length = 13'(n_reg);
            end
            ST_CM_PUT: begin
                emit_req           = (cnt_reg != PW'(4));
                emit_res.kind      = KIND_ECHO;
                emit_res.echo_char = exit_char(cnt_reg[1:0]);
            end
            ST_CM_FAIL: begin
                emit_req              = 1'b1;
                emit_res.kind         = KIND_FAIL;
                emit_res.range_start  = 12'(ps_reg);
                emit_res.range_length = 13'(wp_reg - ps_reg);
            end
            ST_CP_DONE: begin
                emit_req              = 1'b1;
                emit_res.kind         = KIND_RECALL;
                emit_res.range_start  = 12'(dest_reg);
                emit_res.range_length = 13'(len_reg);
            end
            default: begin
                emit_req = 1'b0;
            end
        endcase
    end

    // held result goes out when a newer one replaces it or the byte ends
    assign emit_ok = !pend_valid_reg || out_free;
    assign emit_go = emit_req && emit_ok;

    always_comb begin
        push       = pend_reg;
        push.valid = pend_valid_reg &&
                     (emit_go || (state_reg == ST_FINISH && out_free));
        push.last  = (state_reg == ST_FINISH);
    end

    // store read address
    always_comb begin
        case (state_reg)
            ST_ER_RD, ST_AR_RD: rd_pos = wp_reg - PW'(1);
            ST_SR_RD:           rd_pos = i_reg - PW'(1);
            ST_CM_RD:           rd_pos = ps_reg + cnt_reg;
            ST_CP_RD:           rd_pos = start_reg + cnt_reg;
            default:            rd_pos = '0;
        endcase
    end
    assign mem_raddr = rd_pos[AW-1:0];

    // store write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = put_addr;
        mem_wdata = k_reg;
        case (state_reg)
            ST_ORD_ECHO: begin
                mem_we = emit_go;
            end
            ST_CM_PUT: begin
                mem_we    = emit_go;
                mem_wdata = exit_char(cnt_reg[1:0]);
            end
            ST_CP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = cp_pos[AW-1:0];
                mem_wdata = mem_rdata;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= ESC_NONE;
            wp_reg          <= '0;
            ps_reg          <= '0;
            hd_reg          <= '0;
            pend_valid_reg  <= 1'b0;
            plain_after_reg <= 1'b0;
            arrow_reg       <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        byte_reg  <= s_data_byte;
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    phase_reg       <= ESC_NONE;
                    plain_after_reg <= 1'b0;
                    n_reg           <= '0;
                    arrow_reg       <= 1'b1;
                    case (phase_reg)
                        ESC_SEEN: begin
                            if (byte_reg == CH_LBRACKET) begin
                                phase_reg <= ESC_CSI;
                                state_reg <= ST_FINISH;
                            end else begin
                                // lone ESC is stored, then this byte as usual
                                k_reg           <= CH_ESC;
                                plain_after_reg <= 1'b1;
                                state_reg       <= ST_ORD_ECHO;
                            end
                        end
                        ESC_CSI: begin
                            if (byte_reg == CH_UP) begin
                                if (hd_reg != DEPTH_MAX) begin
                                    hd_reg <= hd_reg + 12'd1;
                                end
                                state_reg <= ST_AR_RD;
                            end else if (byte_reg == CH_DOWN && hd_reg != '0) begin
                                hd_reg    <= hd_reg - 12'd1;
                                state_reg <= ST_AR_RD;
                            end else begin
                                state_reg <= ST_FINISH;
                            end
                        end
                        default: begin
                            state_reg <= ST_PLAIN;
                        end
                    endcase
                end
                ST_PLAIN: begin
                    plain_after_reg <= 1'b0;
                    n_reg           <= '0;
                    arrow_reg       <= 1'b0;
                    if (byte_reg < CH_BS) begin
                        state_reg <= ST_FINISH;
                    end else if (byte_reg == CH_BS || byte_reg == CH_DEL) begin
                        state_reg <= ST_ER_RD;
                    end else if (byte_reg == CH_ESC) begin
                        phase_reg <= ESC_SEEN;
                        state_reg <= ST_FINISH;
                    end else if (byte_reg == CH_TAB) begin
                        state_reg <= ST_CM_START;
                    end else begin
                        k_reg     <= (byte_reg == CH_CR) ? CH_LF : byte_reg;
                        state_reg <= ST_ORD_ECHO;
                    end
                end
                ST_ORD_ECHO: begin
                    if (emit_go) begin
                        wp_reg <= put_wp;
                        if (put_wrap) begin
                            ps_reg <= '0;
                        end
                        if (k_reg == CH_LF) begin
                            state_reg <= ST_ORD_COMMIT;
                        end else begin
                            hd_reg    <= '0;
                            state_reg <= next_plain ? ST_PLAIN : ST_FINISH;
                        end
                    end
                end
                ST_ORD_COMMIT: begin
                    if (emit_go) begin
                        if (wp_reg >= BUF_P) begin
                            wp_reg <= '0;
                            ps_reg <= '0;
                        end else begin
                            ps_reg <= wp_reg;
                        end
                        hd_reg    <= '0;
                        state_reg <= next_plain ? ST_PLAIN : ST_FINISH;
                    end
                end
                // erase one character backwards
                ST_ER_RD: begin
                    if (wp_reg > ps_reg && wp_reg != '0) begin
                        wp_reg    <= wp_reg - PW'(1);
                        n_reg     <= n_reg + PW'(1);
                        state_reg <= ST_ER_CHK;
                    end else begin
                        state_reg <= ST_ER_EMIT;
                    end
                end
                ST_ER_CHK: begin
                    if (mem_rdata < CONT_LO || mem_rdata > CONT_HI) begin
                        state_reg <= ST_ER_EMIT;
                    end else begin
                        state_reg <= ST_ER_RD;
                    end
                end
                ST_ER_EMIT: begin
                    if (!emit_req || emit_go) begin
                        state_reg <= arrow_reg ? ST_AR_POST : ST_FINISH;
                    end
                end
                // clear back to the previous line end
                ST_AR_RD: begin
                    state_reg <= (wp_reg != '0) ? ST_AR_CHK : ST_ER_EMIT;
                end
                ST_AR_CHK: begin
                    if (mem_rdata != CH_LF) begin
                        wp_reg    <= wp_reg - PW'(1);
                        n_reg     <= n_reg + PW'(1);
                        state_reg <= ST_AR_RD;
                    end else begin
                        state_reg <= ST_ER_EMIT;
                    end
                end
                ST_AR_POST: begin
                    if (ps_reg > wp_reg) begin
                        ps_reg <= wp_reg;
                    end
                    i_reg     <= wp_reg;
                    t_reg     <= '0;
                    end_reg   <= '0;
                    state_reg <= (hd_reg == '0) ? ST_FINISH : ST_SR_RD;
                end
                // scan backwards for the n-th earlier line
                ST_SR_RD: begin
                    state_reg <= (i_reg == '0) ? ST_FINISH : ST_SR_CHK;
                end
                ST_SR_CHK: begin
                    i_reg <= i_reg - PW'(1);
                    if (!sr_brk) begin
                        state_reg <= ST_SR_RD;
                    end else if (t_reg == hd_reg) begin
                        start_reg <= sr_start;
                        len_reg   <= (end_reg > sr_start) ? end_reg - sr_start : '0;
                        state_reg <= ST_CP_SETUP;
                    end else begin
                        t_reg     <= t_reg + 12'd1;
                        end_reg   <= i_reg - PW'(1);
                        state_reg <= ST_SR_RD;
                    end
                end
                ST_CP_SETUP: begin
                    if (wp_reg >= BUF_P ||
                        ({1'b0, wp_reg} + {1'b0, len_reg}) > BUF_X) begin
                        dest_reg <= '0;
                    end else begin
                        dest_reg <= wp_reg;
                    end
                    cnt_reg   <= '0;
                    state_reg <= ST_CP_RD;
                end
                ST_CP_RD: begin
                    state_reg <= (cnt_reg == len_reg) ? ST_CP_DONE : ST_CP_WR;
                end
                ST_CP_WR: begin
                    cnt_reg   <= cnt_reg + PW'(1);
                    state_reg <= ST_CP_RD;
                end
                ST_CP_DONE: begin
                    if (emit_go) begin
                        ps_reg    <= dest_reg;
                        wp_reg    <= dest_reg + len_reg;
                        state_reg <= ST_FINISH;
                    end
                end
                // tab completion against "exit"
                ST_CM_START: begin
                    cnt_reg <= '0;
                    len_reg <= wp_reg - ps_reg;
                    if (ps_reg <= wp_reg && (wp_reg - ps_reg) < PW'(4)) begin
                        state_reg <= ST_CM_RD;
                    end else begin
                        state_reg <= ST_CM_FAIL;
                    end
                end
                ST_CM_RD: begin
                    state_reg <= (cnt_reg == len_reg) ? ST_CM_PUT : ST_CM_CHK;
                end
                ST_CM_CHK: begin
                    if (mem_rdata == exit_char(cnt_reg[1:0])) begin
                        cnt_reg   <= cnt_reg + PW'(1);
                        state_reg <= ST_CM_RD;
                    end else begin
                        state_reg <= ST_CM_FAIL;
                    end
                end
                ST_CM_PUT: begin
                    if (!emit_req) begin
                        state_reg <= ST_FINISH;
                    end else if (emit_go) begin
                        wp_reg  <= put_wp;
                        cnt_reg <= cnt_reg + PW'(1);
                        if (put_wrap) begin
                            ps_reg <= '0;
                        end
                    end
                end
                ST_CM_FAIL: begin
                    if (emit_go) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (emit_ok) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // held result
            if (emit_go) begin
                pend_reg       <= emit_res;
                pend_valid_reg <= 1'b1;
            end else if (state_reg == ST_FINISH && out_free) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[tb/tb_console_line_editor_top.sv]
`timescale 1ns / 1ps
module tb_console_line_editor_top;
    import cle_pkg::*;

    localparam int STORE_BYTES = 4096;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  echo_char;
        logic [11:0] range_start;
        logic [12:0] range_length;
        logic        last;
    } editor_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [7:0]  m_echo_char;
    logic [11:0] m_range_start;
    logic [12:0] m_range_length;
    logic        m_last;

    console_line_editor_top #(.BUFFER_BYTES(STORE_BYTES)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_echo_char(m_echo_char), .m_range_start(m_range_start),
        .m_range_length(m_range_length), .m_last(m_last)
    );

    always #10 aclk = ~aclk;

    // editor state mirror
    logic [7:0]   ed_store [STORE_BYTES];
    int           ed_wpos;
    int           ed_pstart;
    int           ed_depth;
    logic [1:0]   ed_esc;
    editor_word_t step_words [$];
    editor_word_t pending_words [$];

    int  fail_count = 0;
    int  cycle_count = 0;
    bit  quiet = 0;
    int  hold_off = 0;
    int  stall_left = 0;

    function void add_word(logic [2:0] k, int ch, int st, int len);
        editor_word_t w;
        if (step_words.size() >= 4) return;
        w.kind = k;
        w.echo_char = ch[7:0];
        w.range_start = st[11:0];
        w.range_length = len[12:0];
        w.last = 1'b0;
        step_words.push_back(w);
    endfunction

    function void store_byte(logic [7:0] b);
        if (ed_wpos >= STORE_BYTES) begin
            ed_wpos = 0;
            ed_pstart = 0;
        end
        ed_store[ed_wpos] = b;
        ed_wpos++;
    endfunction

    function void store_ordinary(logic [7:0] k);
        if (k == CH_CR) k = CH_LF;
        add_word(KIND_ECHO, k, 0, 0);
        store_byte(k);
        if (k == CH_LF) begin
            add_word(KIND_COMMIT, 0, ed_pstart, ed_wpos - ed_pstart);
            ed_pstart = ed_wpos;
            if (ed_wpos >= STORE_BYTES) begin
                ed_wpos = 0;
                ed_pstart = 0;
            end
        end
        ed_depth = 0;
    endfunction

    // erase one UTF-8 character, continuation bytes included
    function void erase_char();
        int n;
        logic [7:0] b;
        n = 0;
        while (ed_wpos > 0 && ed_wpos > ed_pstart) begin
            ed_wpos--;
            b = ed_store[ed_wpos];
            n++;
            if (b < CONT_LO || b > CONT_HI) break;
        end
        if (n > 0) add_word(KIND_ERASE, 0, 0, n);
    endfunction

    function logic [7:0] exit_word(int i);
        logic [7:0] w [4] = '{8'h65, 8'h78, 8'h69, 8'h74};
        return w[i];
    endfunction

    function void complete_exit();
        int len;
        bit hit;
        len = ed_wpos - ed_pstart;
        hit = (ed_pstart <= ed_wpos) && (len < 4);
        if (hit)
            for (int i = 0; i < len; i++)
                if (ed_store[ed_pstart + i] != exit_word(i)) hit = 0;
        if (hit) begin
            for (int i = len; i < 4; i++) begin
                add_word(KIND_ECHO, exit_word(i), 0, 0);
                store_byte(exit_word(i));
            end
        end else begin
            add_word(KIND_FAIL, 0, ed_pstart, ed_wpos - ed_pstart);
        end
    endfunction

    // clear the line, then recall the line at the current depth
    function void history_step(logic [7:0] k);
        int n, t, stop, j, from, len, dest;
        logic [7:0] tmp [$];
        n = 0; t = 0; stop = 0;
        if (k == CH_UP) begin
            if (ed_depth < DEPTH_MAX) ed_depth++;
        end else begin
            if (ed_depth == 0) return;
            ed_depth--;
        end
        while (ed_wpos > 0 && ed_store[ed_wpos - 1] != CH_LF) begin
            ed_wpos--;
            n++;
        end
        if (n > 0) add_word(KIND_ERASE, 0, 0, n);
        if (ed_pstart > ed_wpos) ed_pstart = ed_wpos;
        if (ed_depth == 0) return;
        for (int i = ed_wpos; i > 0; i--) begin
            j = i - 1;
            if (j > 0 && ed_store[j] != CH_LF) continue;
            if (t == ed_depth) begin
                from = (ed_store[j] == CH_LF) ? j + 1 : j;
                len = (stop > from) ? stop - from : 0;
                dest = ed_wpos;
                if (dest >= STORE_BYTES || dest + len > STORE_BYTES) dest = 0;
                for (int m = 0; m < len; m++) tmp.push_back(ed_store[from + m]);
                for (int m = 0; m < len; m++) ed_store[dest + m] = tmp[m];
                ed_pstart = dest;
                ed_wpos = dest + len;
                add_word(KIND_RECALL, 0, dest, len);
                return;
            end
            t++;
            stop = j;
        end
    endfunction

    function void plain_byte(logic [7:0] b);
        if (b < CH_BS) return;
        if (b == CH_BS || b == CH_DEL) erase_char();
        else if (b == CH_ESC) ed_esc = ESC_SEEN;
        else if (b == CH_TAB) complete_exit();
        else store_ordinary(b);
    endfunction

    // work out the result words of one accepted byte
    function void predict_byte(logic [7:0] b);
        logic [1:0] phase;
        phase = ed_esc;
        step_words.delete();
        ed_esc = ESC_NONE;
        if (phase == ESC_SEEN) begin
            if (b == CH_LBRACKET) ed_esc = ESC_CSI;
            else begin
                store_ordinary(CH_ESC);
                plain_byte(b);
            end
        end else if (phase == ESC_CSI) begin
            if (b == CH_UP || b == CH_DOWN) history_step(b);
        end else begin
            plain_byte(b);
        end
        if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
        foreach (step_words[i]) pending_words.push_back(step_words[i]);
    endfunction

    // result checker
    always @(posedge aclk) begin
        editor_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word kind %0d", $time, m_kind);
                fail_count++;
            end else begin
                e = pending_words.pop_front();
                if (m_kind !== e.kind || m_echo_char !== e.echo_char ||
                    m_range_start !== e.range_start ||
                    m_range_length !== e.range_length || m_last !== e.last) begin
                    $display("%0t: mismatch exp k%0d c%02h s%0d l%0d last%0d",
                             $time, e.kind, e.echo_char, e.range_start,
                             e.range_length, e.last);
                    $display("%0t:          act k%0d c%02h s%0d l%0d last%0d",
                             $time, m_kind, m_echo_char, m_range_start,
                             m_range_length, m_last);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stall bursts, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            m_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left <= int'($urandom_range(0, 3));
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL console_line_editor_top");
            $finish;
        end
    end

    // offer one word and wait for it to be taken
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        predict_byte(b);
    endtask

    // stop offering until the block is idle and every word has come
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words.size() != 0 || !s_ready) @(posedge aclk);
        repeat (4 * ed_wpos + 50) @(posedge aclk);
    endtask

    task automatic send_csi(logic [7:0] k);
        send_byte(CH_ESC);
        send_byte(CH_LBRACKET);
        send_byte(k);
    endtask

    task automatic test_directed();
        send_byte(8'h00);           // control bytes ignored
        send_byte(8'h07);
        send_byte(CH_TAB);          // empty prefix completes to exit
        send_byte(CH_CR);           // CR commits as LF
        send_byte(8'h65);
        send_byte(CH_TAB);
        send_byte(CH_BS);
        send_byte(CH_DEL);
        send_byte(CH_BS);           // erases x; e is still left on the line
        send_byte(8'hc3);           // two-byte character erased at once
        send_byte(8'ha9);
        send_byte(CH_BS);
        send_byte(8'hff);
        send_byte(CH_LF);
        send_byte(CH_ESC);          // ESC then ordinary byte
        send_byte(8'h78);
        send_byte(CH_ESC);          // ESC [ then junk is dropped
        send_byte(CH_LBRACKET);
        send_byte(8'h7a);
        send_csi(CH_UP);
        send_csi(CH_UP);
        send_csi(CH_UP);            // beyond the oldest line
        send_csi(CH_DOWN);
        send_csi(CH_DOWN);
        send_csi(CH_DOWN);          // down back to depth zero
        send_byte(8'h78);           // full prefix fails to complete
        send_byte(8'h79);
        send_byte(8'h7a);
        send_byte(8'h77);
        send_byte(CH_TAB);
        send_byte(CH_LF);
        drain();
    endtask

    // mostly well-formed editing with random content, some noise
    task automatic test_random(int n_items);
        int sent, sel, len;
        sent = 0;
        while (sent < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                len = $urandom_range(0, 6);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_byte(8'hc0 | 8'($urandom_range(0, 31)));
                        send_byte(8'h80 | 8'($urandom_range(0, 63)));
                        sent += 2;
                    end else begin
                        send_byte(8'($urandom_range(8'h20, 8'h7e)));
                        sent++;
                    end
                end
                send_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
                sent++;
            end else if (sel < 55) begin
                send_csi($urandom_range(0, 2) != 0 ? CH_UP : CH_DOWN);
                sent += 3;
            end else if (sel < 65) begin
                send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
                sent++;
            end else if (sel < 75) begin
                if ($urandom_range(0, 1)) begin
                    send_byte(8'h65);
                    sent++;
                end
                send_byte(CH_TAB);
                sent++;
            end else begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end
        end
        drain();
    endtask

    // long receiver hold-off while bytes keep coming
    task automatic test_backpressure();
        hold_off = 300;
        for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(8'h20, 8'h7e)));
        send_byte(CH_LF);
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        ed_wpos = 0;
        ed_pstart = 0;
        ed_depth = 0;
        ed_esc = ESC_NONE;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(115);
        quiet = 1;
        test_random(40);
        if (fail_count == 0) begin
            $display("PASS console_line_editor_top");
        end else begin
            $display("FAIL console_line_editor_top");
        end
        $finish;
    end

endmodule

[console_line_editor_top.f]
+incdir+hdl
hdl/cle_pkg.sv
hdl/cle_ram.sv
hdl/cle_ctrl.sv
hdl/console_line_editor_top.sv
tb/tb_console_line_editor_top.sv
